// ----- design/rsof_pkg.sv -----
// Shared types and constants of the running statistics outlier flag block.
package rsof_pkg;

  localparam int NUM_ATTRS_DEF = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_3     = 3'd4;

  localparam int THR_W   = 12;
  localparam int CNT_W   = 16;
  localparam int SUM_W   = 32;
  localparam int SQ_W    = 46;
  localparam int MEAN_W  = 24;
  localparam int STD_W   = 23;
  localparam int BAND_W  = THR_W + STD_W;
  localparam int CMP_W   = 37;

  localparam logic [THR_W-1:0] THR_RESET = 12'd768;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [STD_W-1:0] STD_MAX   = 23'h7FFFFF;

  // shared divide / square-root unit
  localparam int IT_W  = 62;
  localparam int REM_W = 28;
  localparam int DVS_W = 16;
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] DIV_STEPS_M1  = 6'd61;
  localparam logic [STEP_W-1:0] SQRT_STEPS_M1 = 6'd23;

  // stream widths
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;

  typedef enum logic {OP_DIV, OP_SQRT} op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } iter_req_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } iter_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MEAN_GO, S_MEAN, S_EX2_GO, S_EX2, S_SQRT_GO, S_SQRT,
    S_BAND, S_CMP, S_UPD, S_FIN
  } state_t;

endpackage

// ----- design/rsof_iter.sv -----
// Shared iterative unit: restoring divide by a 16-bit divisor, or integer square root.
module rsof_iter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rsof_pkg::iter_req_t             req,
  input  logic [rsof_pkg::IT_W-1:0]       operand,
  input  logic [rsof_pkg::DVS_W-1:0]      divisor,
  output rsof_pkg::iter_rsp_t             rsp,
  output logic [rsof_pkg::IT_W-1:0]       result
);

  logic                          busy_r;
  logic                          done_r;
  rsof_pkg::op_t                 op_r;
  logic [rsof_pkg::STEP_W-1:0]   cnt_r;
  logic [rsof_pkg::IT_W-1:0]     src_r;
  logic [rsof_pkg::IT_W-1:0]     acc_r;
  logic [rsof_pkg::REM_W-1:0]    rem_r;
  logic [rsof_pkg::DVS_W-1:0]    dvs_r;

  logic [rsof_pkg::REM_W-1:0]    rem_sh;
  logic [rsof_pkg::REM_W-1:0]    trial;
  logic                          ge;
  logic [rsof_pkg::REM_W-1:0]    rem_nxt;

  // divide brings down one bit a step, square root two
  always_comb begin
    if (op_r == rsof_pkg::OP_DIV) begin
      rem_sh = {rem_r[rsof_pkg::REM_W-2:0], src_r[rsof_pkg::IT_W-1]};
      trial  = {{(rsof_pkg::REM_W-rsof_pkg::DVS_W){1'b0}}, dvs_r};
    end else begin
      rem_sh = {rem_r[rsof_pkg::REM_W-3:0], src_r[rsof_pkg::IT_W-1 -: 2]};
      trial  = {2'b00, acc_r[23:0], 2'b01};
    end
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == rsof_pkg::OP_DIV) ? rsof_pkg::DIV_STEPS_M1
                                               : rsof_pkg::SQRT_STEPS_M1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      src_r <= operand;
      dvs_r <= divisor;
      acc_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      src_r <= (op_r == rsof_pkg::OP_DIV) ? {src_r[rsof_pkg::IT_W-2:0], 1'b0}
                                          : {src_r[rsof_pkg::IT_W-3:0], 2'b00};
      acc_r <= {acc_r[rsof_pkg::IT_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.rem_nz = (rem_r != '0);
  assign result     = acc_r;

endmodule

// ----- design/running_stats_outlier_flag.sv -----
// Top level: per-attribute running statistics, outlier check and object report.
//
// Input stream: in_tdata carries one signed Q8.8 value, in_tuser the attribute
// index and in_tlast marks the last value of an object. Results leave on the
// out_ stream, one per object, once the object's last value is done.
// Configuration: cfg_we writes register cfg_index (0 warm-up count, 1..4 thresholds).
//
// Sequence per request: a value whose attribute count has not passed the warm-up
// count goes through the update and finish states before in_tready is high again,
// one whose attribute index is out of range through the finish state only. A
// checked value runs two 62-step divisions (mean, mean square) and a 24-step
// square root, all on the one shared divide/root unit, plus start and hand-over
// states and the band multiply, the compare and the update.
// in_tready is high only while the sequencer is idle.
//
// Reset (synchronous, rst_n low) clears all statistics, the pending flag and
// the output valid flag, and loads the default thresholds.
// A result held in the output register does not block new requests; only the
// next object end waits until out_tready has taken the previous result.
module running_stats_outlier_flag #(
  parameter int NUM_ATTRS = rsof_pkg::NUM_ATTRS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rsof_pkg::IN_DATA_W-1:0]      in_tdata,   // [15:0] sample
  input  logic [rsof_pkg::IN_USER_W-1:0]      in_tuser,   // [1:0] attr_index
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] anomalous, [2:1] first_index, [18:3] seen_count, [42:19] mean_out,
  // [65:43] stddev_out, [71:66] zero
  output logic [rsof_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [rsof_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsof_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IW = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
  localparam logic [2:0] NUM_ATTRS_V = 3'(NUM_ATTRS);

  // configuration
  logic [rsof_pkg::CNT_W-1:0] warm_cnt_r;
  logic [rsof_pkg::THR_W-1:0] thr_r [4];

  // statistics
  logic [rsof_pkg::CNT_W-1:0]        cnt_r [NUM_ATTRS];
  logic signed [rsof_pkg::SUM_W-1:0] sum_r [NUM_ATTRS];
  logic [rsof_pkg::SQ_W-1:0]         sq_r  [NUM_ATTRS];

  // current request
  rsof_pkg::state_t              state_r, state_nxt;
  logic [rsof_pkg::IN_USER_W-1:0] idx_r;
  logic signed [15:0]            d_r;
  logic                          end_r;
  logic [rsof_pkg::CNT_W-1:0]    c_r;

  logic signed [rsof_pkg::MEAN_W-1:0] mean_r;
  logic [47:0]                        msq_r;
  logic [46:0]                        ex2_r;
  logic [rsof_pkg::STD_W-1:0]         std_r;
  logic [rsof_pkg::BAND_W-1:0]        band_r;

  // object report
  logic                               flag_r;
  logic [rsof_pkg::IN_USER_W-1:0]     rep_idx_r;
  logic [rsof_pkg::CNT_W-1:0]         rep_cnt_r;
  logic [rsof_pkg::MEAN_W-1:0]        rep_mean_r;
  logic [rsof_pkg::STD_W-1:0]         rep_std_r;

  logic                               out_valid_r;
  logic [rsof_pkg::OUT_DATA_W-1:0]    out_data_r;

  // shared unit
  rsof_pkg::iter_req_t           it_req;
  rsof_pkg::iter_rsp_t           it_rsp;
  logic [rsof_pkg::IT_W-1:0]     it_operand;
  logic [rsof_pkg::IT_W-1:0]     it_result;

  logic                          in_acc;
  logic                          in_range_in;
  logic [IW-1:0]                 ai;
  logic [IW-1:0]                 ai_in;
  logic                          sum_neg;
  logic [32:0]                   sum_mag;
  logic [24:0]                   q_mean;
  logic [48:0]                   var_diff;
  logic [47:0]                   var_cl;
  logic [23:0]                   root;
  logic signed [rsof_pkg::CMP_W-1:0] dv, mv, bandx, hi, lo;
  logic                          outlier;
  logic                          out_free;

  assign in_tready   = (state_r == rsof_pkg::S_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign in_range_in = ({1'b0, in_tuser} < NUM_ATTRS_V);
  assign ai          = idx_r[IW-1:0];
  assign ai_in       = in_tuser[IW-1:0];
  assign out_free    = !out_valid_r || out_tready;

  always_comb begin
    sum_neg    = sum_r[ai][rsof_pkg::SUM_W-1];
    sum_mag    = sum_neg ? (33'd0 - {sum_r[ai][rsof_pkg::SUM_W-1], sum_r[ai]})
                         : {1'b0, sum_r[ai]};
    q_mean     = it_result[24:0] + {24'd0, it_rsp.rem_nz};
    var_diff   = {2'b00, ex2_r} - {1'b0, msq_r};
    var_cl     = var_diff[48] ? 48'd0 : var_diff[47:0];
    root       = it_result[23:0];
    dv         = {{5{d_r[15]}}, d_r, 16'd0};
    mv         = {{5{mean_r[rsof_pkg::MEAN_W-1]}}, mean_r, 8'd0};
    bandx      = {2'b00, band_r};
    hi         = mv + bandx;
    lo         = mv - bandx;
    outlier    = (dv > hi) || (dv < lo);
  end

  // operand select for the shared unit
  always_comb begin
    it_req.start = 1'b0;
    it_req.op    = rsof_pkg::OP_DIV;
    it_operand   = '0;
    unique case (state_r)
      rsof_pkg::S_MEAN_GO: begin
        it_req.start = 1'b1;
        it_operand   = {21'd0, sum_mag, 8'd0};
      end
      rsof_pkg::S_EX2_GO: begin
        it_req.start = 1'b1;
        it_operand   = {sq_r[ai], 16'd0};
      end
      rsof_pkg::S_SQRT_GO: begin
        it_req.start = 1'b1;
        it_req.op    = rsof_pkg::OP_SQRT;
        it_operand   = {var_cl, 14'd0};
      end
      default: ;
    endcase
  end

  rsof_iter u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (it_req),
    .operand (it_operand),
    .divisor (c_r),
    .rsp     (it_rsp),
    .result  (it_result)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rsof_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsof_pkg::S_IDLE: begin
        if (in_acc) begin
          if (!in_range_in)                       state_nxt = rsof_pkg::S_FIN;
          else if (cnt_r[ai_in] > warm_cnt_r)     state_nxt = rsof_pkg::S_MEAN_GO;
          else                                    state_nxt = rsof_pkg::S_UPD;
        end
      end
      rsof_pkg::S_MEAN_GO: state_nxt = rsof_pkg::S_MEAN;
      rsof_pkg::S_MEAN:    if (it_rsp.done) state_nxt = rsof_pkg::S_EX2_GO;
      rsof_pkg::S_EX2_GO:  state_nxt = rsof_pkg::S_EX2;
      rsof_pkg::S_EX2:     if (it_rsp.done) state_nxt = rsof_pkg::S_SQRT_GO;
      rsof_pkg::S_SQRT_GO: state_nxt = rsof_pkg::S_SQRT;
      rsof_pkg::S_SQRT:    if (it_rsp.done) state_nxt = rsof_pkg::S_BAND;
      rsof_pkg::S_BAND:    state_nxt = rsof_pkg::S_CMP;
      rsof_pkg::S_CMP:     state_nxt = rsof_pkg::S_UPD;
      rsof_pkg::S_UPD:     state_nxt = rsof_pkg::S_FIN;
      rsof_pkg::S_FIN:     if (!end_r || out_free) state_nxt = rsof_pkg::S_IDLE;
      default:             state_nxt = rsof_pkg::S_IDLE;
    endcase
  end

  // request capture and datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r <= in_tuser;
      d_r   <= signed'(in_tdata);
      end_r <= in_tlast;
      c_r   <= in_range_in ? cnt_r[ai_in] : '0;
    end
    if (state_r == rsof_pkg::S_MEAN && it_rsp.done) begin
      mean_r <= sum_neg ? rsof_pkg::MEAN_W'(25'd0 - q_mean)
                        : it_result[rsof_pkg::MEAN_W-1:0];
    end
    if (state_r == rsof_pkg::S_EX2_GO) msq_r <= 48'(mean_r * mean_r);
    if (state_r == rsof_pkg::S_EX2 && it_rsp.done) ex2_r <= it_result[46:0];
    if (state_r == rsof_pkg::S_SQRT && it_rsp.done) begin
      std_r <= root[23] ? rsof_pkg::STD_MAX : root[rsof_pkg::STD_W-1:0];
    end
    if (state_r == rsof_pkg::S_BAND) begin
      band_r <= rsof_pkg::BAND_W'(thr_r[idx_r] * std_r);
    end
  end

  // statistics, report, output and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ATTRS; i++) begin
        cnt_r[i] <= '0;
        sum_r[i] <= '0;
        sq_r[i]  <= '0;
      end
      warm_cnt_r  <= '0;
      for (int i = 0; i < 4; i++) thr_r[i] <= rsof_pkg::THR_RESET;
      flag_r      <= 1'b0;
      rep_idx_r   <= '0;
      rep_cnt_r   <= '0;
      rep_mean_r  <= '0;
      rep_std_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rsof_pkg::REG_WARMUP:    warm_cnt_r <= cfg_wdata;
          rsof_pkg::REG_THR_0:     thr_r[0] <= cfg_wdata[rsof_pkg::THR_W-1:0];
          rsof_pkg::REG_THR_1:     thr_r[1] <= cfg_wdata[rsof_pkg::THR_W-1:0];
          rsof_pkg::REG_THR_2:     thr_r[2] <= cfg_wdata[rsof_pkg::THR_W-1:0];
          rsof_pkg::REG_THR_3:     thr_r[3] <= cfg_wdata[rsof_pkg::THR_W-1:0];
          default: ;
        endcase
      end

      if (state_r == rsof_pkg::S_CMP && outlier && !flag_r) begin
        flag_r     <= 1'b1;
        rep_idx_r  <= idx_r;
        rep_cnt_r  <= c_r;
        rep_mean_r <= mean_r;
        rep_std_r  <= std_r;
      end

      // a saturated count freezes the attribute's statistics
      if (state_r == rsof_pkg::S_UPD && c_r != rsof_pkg::COUNT_MAX) begin
        cnt_r[ai] <= c_r + 1'b1;
        sum_r[ai] <= sum_r[ai] + rsof_pkg::SUM_W'(d_r);
        sq_r[ai]  <= sq_r[ai] + rsof_pkg::SQ_W'(unsigned'(32'(d_r * d_r)));
      end

      if (state_r == rsof_pkg::S_FIN && end_r && out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {6'd0, rep_std_r, rep_mean_r, rep_cnt_r, rep_idx_r, flag_r};
        flag_r      <= 1'b0;
        rep_idx_r   <= '0;
        rep_cnt_r   <= '0;
        rep_mean_r  <= '0;
        rep_std_r   <= '0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- design/rsof_check.sv -----
// Port-level checks of the outlier flag block, bound to the top level.
module rsof_check (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rsof_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // every accepted request takes the sequencer out of idle, so in_tready falls
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready straight after a request");

  // a clean object reports all-zero figures
  a_clean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[rsof_pkg::OUT_DATA_W-1:1] == '0)
    else $error("clean object with non-zero figures");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind running_stats_outlier_flag rsof_check u_rsof_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the running statistics outlier flag block.
`timescale 1ns / 1ps

module testbench;

  localparam logic [rsof_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [rsof_pkg::IN_DATA_W-1:0] in_tdata = '0;   // [15:0] sample
  logic [rsof_pkg::IN_USER_W-1:0] in_tuser = '0;   // [1:0] attr_index
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [0] anomalous, [2:1] first_index, [18:3] seen_count, [42:19] mean_out,
  // [65:43] stddev_out, [71:66] zero
  logic [rsof_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [rsof_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rsof_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  running_stats_outlier_flag u_top (.*);

  always #6 clk = ~clk;

  typedef struct packed {
    logic [22:0] stddev;
    logic [23:0] mean;
    logic [15:0] seen;
    logic [1:0]  first;
    logic        anomalous;
  } report_t;

  // predictor state
  logic [15:0] min_cnt;
  logic [11:0] thr [4];
  logic [15:0] cnt [4];
  longint      sum_q [4];
  longint      sq_sum [4];
  logic        flagged;
  report_t     held;

  report_t expected_reports [$];
  int errors = 0;
  int sent = 0;
  int long_hold = 0;
  int stall_mode = 0;
  bit quiet_sender = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH: %s", what);
  endtask

  function automatic longint fdiv(input longint num, input longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // bit-by-bit integer square root, floor
  function automatic longint root(input longint v);
    longint unsigned x, r, b;
    x = v;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  task automatic predict(input logic [1:0] a, input logic [15:0] raw, input logic last);
    longint d, m, var_q, s, dv, mv, band;
    longint unsigned ex2;
    d = longint'($signed(raw));
    if (cnt[a] > min_cnt) begin
      m = fdiv(sum_q[a] * 256, cnt[a]);
      ex2 = (longint'(sq_sum[a]) << 16) / cnt[a];
      var_q = longint'(ex2) - m * m;
      if (var_q < 0) var_q = 0;
      s = root(var_q);
      if (s > 8388607) s = 8388607;
      dv = d * 65536;
      mv = m * 256;
      band = longint'(thr[a]) * s;
      if ((dv > mv + band || dv < mv - band) && !flagged) begin
        flagged = 1'b1;
        held = '{stddev: s[22:0], mean: m[23:0], seen: cnt[a], first: a, anomalous: 1'b1};
      end
    end
    if (cnt[a] != 16'hFFFF) begin
      cnt[a]++;
      sum_q[a] += d;
      sq_sum[a] += d * d;
    end
    if (last) begin
      expected_reports.push_back(flagged ? held : report_t'('0));
      flagged = 1'b0;
      held = '0;
    end
  endtask

  // one request; random gap before it unless bursting
  task automatic send_value(input logic [1:0] a, input logic [15:0] v, input logic last);
    if (!quiet_sender && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= a;
    in_tdata <= v;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict(a, v, last);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_object(input int n, input int spread);
    for (int i = 0; i < n; i++)
      send_value(i[1:0], 16'(spread == 0 ? $urandom : 256 + $urandom_range(0, spread)
        - spread / 2), i == n - 1);
  endtask

  task automatic drain;
    int guard = 0;
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0 && guard < 400000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rsof_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      rsof_pkg::REG_WARMUP: min_cnt = v;
      rsof_pkg::REG_THR_0, rsof_pkg::REG_THR_1, rsof_pkg::REG_THR_2,
      rsof_pkg::REG_THR_3: thr[idx - rsof_pkg::REG_THR_0] = v[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: checks each result against the oldest expectation
  always @(posedge clk) begin
    report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[65:0];
      if (out_tdata[71:66] != 0) report_mismatch("padding bits set");
      if (expected_reports.size() == 0) begin
        report_mismatch("result with none pending");
      end else begin
        want = expected_reports.pop_front();
        if (got.anomalous != want.anomalous) report_mismatch("anomalous");
        if (got.first != want.first) report_mismatch("first_index");
        if (got.seen != want.seen) report_mismatch("seen_count");
        if (got.mean != want.mean) report_mismatch("mean_out");
        if (got.stddev != want.stddev) report_mismatch("stddev_out");
      end
    end
  end

  always @(negedge clk) begin
    if (long_hold > 0) begin
      long_hold--;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 2) != 0);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic test_defaults;
    // the first value of each attribute is never checked
    send_value(2'd0, 16'h7FFF, 1'b0);
    send_value(2'd1, 16'h8000, 1'b0);
    send_value(2'd2, 16'h0000, 1'b0);
    send_value(2'd3, 16'hFFFF, 1'b1);
    for (int i = 0; i < 6; i++) send_object(4, 64);
    // outliers both ways, several flags in one object
    send_value(2'd0, 16'h8000, 1'b0);
    send_value(2'd1, 16'h7FFF, 1'b0);
    send_value(2'd2, 16'h5555, 1'b0);
    send_value(2'd3, 16'hAAAA, 1'b1);
    send_value(2'd3, 16'h0100, 1'b1);
    drain();
  endtask

  task automatic test_registers;
    write_reg(rsof_pkg::REG_WARMUP, 16'hFFFF);
    write_reg(rsof_pkg::REG_THR_0, 16'h0000);
    write_reg(rsof_pkg::REG_THR_1, 16'h0FFF);
    write_reg(rsof_pkg::REG_THR_2, 16'h0001);
    write_reg(rsof_pkg::REG_THR_3, 16'h0100);
    write_reg(REG_NONE, 16'h1234); // out of range: ignored
    send_object(4, 0);
    drain();
    write_reg(rsof_pkg::REG_WARMUP, 16'h0003);
    for (int i = 0; i < 8; i++) send_object(4, 600);
    drain();
  endtask

  task automatic test_random(input int n);
    int k;
    for (int p = 0; p < 3; p++) begin
      stall_mode = p;
      write_reg(rsof_pkg::REG_WARMUP, 16'($urandom_range(0, 12)));
      for (int t = 0; t < 4; t++)
        write_reg(3'(rsof_pkg::REG_THR_0 + t), 16'($urandom_range(0, 4095)));
      k = 0;
      while (k < n) begin
        quiet_sender = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 9) == 0) begin
          // noise: random attribute order and ends
          send_value(2'($urandom), 16'($urandom), 1'($urandom));
          k++;
        end else begin
          send_object($urandom_range(1, 4), $urandom_range(0, 3) == 0 ? 0 : 2000);
          k += 3;
        end
      end
      quiet_sender = 0;
      drain();
    end
  endtask

  task automatic test_backpressure;
    stall_mode = 0;
    quiet_sender = 1;
    @(negedge clk);
    long_hold = 3000;
    for (int i = 0; i < 8; i++) send_object(4, 3000);
    quiet_sender = 0;
    drain();
  endtask

  initial begin
    min_cnt = 16'd0;
    for (int i = 0; i < 4; i++) begin
      thr[i] = rsof_pkg::THR_RESET;
      cnt[i] = '0;
      sum_q[i] = 0;
      sq_sum[i] = 0;
    end
    flagged = 1'b0;
    held = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_registers();
    test_backpressure();
    test_random(220);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
